// ===== src/gesture_direction_extractor_assert.svh =====
// assertion macros used by the gesture direction extractor back end
`ifndef GESTURE_DIRECTION_EXTRACTOR_ASSERT_SVH
`define GESTURE_DIRECTION_EXTRACTOR_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst is high
`define GDE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gesture extractor check failed");

// next-cycle implication, sampled on clk, off while rst is high
`define GDE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gesture extractor check failed");

`endif

// ===== src/gde_pkg.sv =====
// shared types and constants of the gesture direction extractor
`timescale 1ns / 1ps
`default_nettype none
package gde_pkg;

  localparam int MAX_POINTS_DEF  = 64;
  localparam int COORD_BITS_DEF  = 12;
  localparam int OUT_BITS        = 19;
  localparam int CNT_BITS        = 6;
  localparam int MATCH_BITS      = 9;
  localparam int FRAC_BITS       = 8;
  localparam logic [MATCH_BITS-1:0] MATCH_RESET = 9'd205;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_MOVE  = 2'd1,
    CMD_END   = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  // one queued operation: write a point, and/or close the gesture
  typedef struct packed {
    logic wr;
    logic fin;
  } op_ctrl_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_BRD,
    S_BPROC,
    S_FLUSH,
    S_MUL,
    S_SRD,
    S_SPROC,
    S_DECIDE,
    S_RRD,
    S_RPROC,
    S_ERD,
    S_ELD,
    S_EMPTY
  } back_state_t;

endpackage
`default_nettype wire

// ===== src/gde_ram.sv =====
// generic single write port, single read port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module gde_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== src/gde_fifo.sv =====
// two-entry request queue between front and back
`timescale 1ns / 1ps
`default_nettype none
module gde_fifo #(
  parameter int W = 8
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  wire logic [W-1:0] din,
  output logic              ready,
  output logic              valid,
  input  wire logic         pop,
  output logic      [W-1:0] dout
);

  logic [W-1:0] slot [2];
  logic         wp;
  logic         rp;
  logic [1:0]   cnt;
  logic         push_ok;
  logic         pop_ok;

  assign ready   = (cnt != 2'd2);
  assign valid   = (cnt != 2'd0);
  assign push_ok = push & ready;
  assign pop_ok  = pop & valid;
  assign dout    = slot[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push_ok) begin
        wp <= ~wp;
      end
      if (pop_ok) begin
        rp <= ~rp;
      end
      cnt <= cnt + {1'b0, push_ok} - {1'b0, pop_ok};
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      slot[wp] <= din;
    end
  end

endmodule
`default_nettype wire

// ===== src/gde_front.sv =====
// request front: decodes commands, filters points, queues store and end requests
`timescale 1ns / 1ps
`default_nettype none
module gde_front #(
  parameter int MAX_POINTS = 64,
  parameter int COORD_BITS = 12,
  parameter int AW         = 6,
  parameter int NW         = 7
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [1:0]            command,
  input  wire logic [COORD_BITS-1:0] pos_x,
  input  wire logic [COORD_BITS-1:0] pos_y,
  input  wire logic                  q_ready,
  output logic                       q_push,
  output gde_pkg::op_ctrl_t          q_ctrl,
  output logic      [AW-1:0]         q_addr,
  output logic      [COORD_BITS-1:0] q_x,
  output logic      [COORD_BITS-1:0] q_y,
  output logic      [NW-1:0]         q_npts
);
  import gde_pkg::*;

  logic [NW-1:0]         count;
  logic [NW-1:0]         count_next;
  logic                  active;
  logic                  active_next;
  logic [COORD_BITS-1:0] last_x;
  logic [COORD_BITS-1:0] last_x_next;
  logic [COORD_BITS-1:0] last_y;
  logic [COORD_BITS-1:0] last_y_next;

  logic                  acc;
  cmd_t                  cmd;
  logic signed [COORD_BITS:0] fdx;
  logic signed [COORD_BITS:0] fdy;
  logic [COORD_BITS:0]   fadx;
  logic [COORD_BITS:0]   fady;
  logic                  near;
  logic                  has_room;
  logic                  keep_end;

  assign in_ready = q_ready;
  assign acc      = in_valid & q_ready;
  assign cmd      = cmd_t'(command);
  assign q_x      = pos_x;
  assign q_y      = pos_y;

  assign fdx  = $signed({1'b0, pos_x}) - $signed({1'b0, last_x});
  assign fdy  = $signed({1'b0, pos_y}) - $signed({1'b0, last_y});
  assign fadx = fdx[COORD_BITS] ? (COORD_BITS+1)'(-fdx) : (COORD_BITS+1)'(fdx);
  assign fady = fdy[COORD_BITS] ? (COORD_BITS+1)'(-fdy) : (COORD_BITS+1)'(fdy);

  // squared distance below 5
  assign near = ((fadx <= (COORD_BITS+1)'(1)) && (fady <= (COORD_BITS+1)'(1))) ||
                ((fadx == (COORD_BITS+1)'(2)) && (fady == '0)) ||
                ((fadx == '0) && (fady == (COORD_BITS+1)'(2)));
  assign has_room = (count < NW'(MAX_POINTS));
  assign keep_end = ((pos_x != last_x) || (pos_y != last_y)) && has_room;

  always_comb begin
    count_next  = count;
    active_next = active;
    last_x_next = last_x;
    last_y_next = last_y;
    q_push      = 1'b0;
    q_ctrl      = '0;
    q_addr      = count[AW-1:0];
    q_npts      = count;
    if (acc) begin
      unique case (cmd)
        CMD_START: begin
          q_push      = 1'b1;
          q_ctrl.wr   = 1'b1;
          q_addr      = '0;
          count_next  = NW'(1);
          active_next = 1'b1;
          last_x_next = pos_x;
          last_y_next = pos_y;
        end
        CMD_MOVE: begin
          if (active && !near && has_room) begin
            q_push      = 1'b1;
            q_ctrl.wr   = 1'b1;
            count_next  = count + NW'(1);
            last_x_next = pos_x;
            last_y_next = pos_y;
          end
        end
        CMD_END: begin
          if (active) begin
            q_push      = 1'b1;
            q_ctrl.fin  = 1'b1;
            q_ctrl.wr   = keep_end;
            q_npts      = keep_end ? count + NW'(1) : count;
            count_next  = '0;
            active_next = 1'b0;
          end
        end
        CMD_NONE: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      active <= 1'b0;
    end else begin
      count  <= count_next;
      active <= active_next;
    end
  end

  always_ff @(posedge clk) begin
    last_x <= last_x_next;
    last_y <= last_y_next;
  end

endmodule
`default_nettype wire

// ===== src/gde_back.sv =====
// execution back end: point store, stroke extraction, reduction and result output
`timescale 1ns / 1ps
`default_nettype none
`include "gesture_direction_extractor_assert.svh"
module gde_back #(
  parameter int MAX_POINTS = 64,
  parameter int COORD_BITS = 12,
  parameter int AW         = 6,
  parameter int NW         = 7,
  parameter int SW         = 19
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic [gde_pkg::MATCH_BITS-1:0]    min_match,
  input  wire logic                              q_valid,
  output logic                                   q_pop,
  input  wire gde_pkg::op_ctrl_t                 q_ctrl,
  input  wire logic [AW-1:0]                     q_addr,
  input  wire logic [COORD_BITS-1:0]             q_x,
  input  wire logic [COORD_BITS-1:0]             q_y,
  input  wire logic [NW-1:0]                     q_npts,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic signed [gde_pkg::OUT_BITS-1:0]    seg_dx,
  output logic signed [gde_pkg::OUT_BITS-1:0]    seg_dy,
  output logic                                   segment_valid,
  output logic [gde_pkg::CNT_BITS-1:0]           up_count,
  output logic [gde_pkg::CNT_BITS-1:0]           down_count,
  output logic [gde_pkg::CNT_BITS-1:0]           left_count,
  output logic [gde_pkg::CNT_BITS-1:0]           right_count,
  output logic                                   last_segment
);
  import gde_pkg::*;

  localparam int FW = SW + MATCH_BITS;

  back_state_t state;
  back_state_t state_next;

  logic [NW-1:0]         npts;
  logic [NW-1:0]         i;
  logic [AW-1:0]         m;
  logic [AW-1:0]         n;
  logic [AW-1:0]         j;
  logic [AW-1:0]         k;
  logic [AW-1:0]         e;
  logic                  first;
  logic                  building;
  logic signed [SW-1:0]  lx;
  logic signed [SW-1:0]  ly;
  logic [COORD_BITS-1:0] prev_x;
  logic [COORD_BITS-1:0] prev_y;
  logic [SW-1:0]         tot;
  logic [SW-1:0]         curtot;
  logic [SW-1:0]         bestlen;
  logic [FW-1:0]         floor_len;
  logic [AW-1:0]         up_cnt;
  logic [AW-1:0]         down_cnt;
  logic [AW-1:0]         left_cnt;
  logic [AW-1:0]         right_cnt;

  logic                      pr_we;
  logic                      pr_re;
  logic [2*COORD_BITS-1:0]   pr_rdata;
  logic                      sg_we;
  logic                      sg_re;
  logic [AW-1:0]             sg_raddr;
  logic [2*SW-1:0]           sg_rdata;

  logic [COORD_BITS-1:0]       px;
  logic [COORD_BITS-1:0]       py;
  logic signed [COORD_BITS:0]  sdx;
  logic signed [COORD_BITS:0]  sdy;
  logic [COORD_BITS:0]         adx;
  logic [COORD_BITS:0]         ady;
  logic signed [SW-1:0]        stx;
  logic signed [SW-1:0]        sty;
  logic signed [SW-1:0]        sx;
  logic signed [SW-1:0]        sy;
  logic signed [SW-1:0]        cx;
  logic signed [SW-1:0]        cy;
  logic                        jx;
  logic                        jy;
  logic                        feed;
  logic [SW-1:0]               clen;
  logic [SW-1:0]               slen;
  logic [SW-1:0]               rest;
  logic                        remove;
  logic                        slot_free;
  logic                        e_last;

  function automatic logic [SW-1:0] mag(input logic signed [SW-1:0] v);
    mag = v[SW-1] ? SW'(-v) : SW'(v);
  endfunction

  gde_ram #(
    .WIDTH (2*COORD_BITS),
    .DEPTH (MAX_POINTS),
    .AW    (AW)
  ) u_point_ram (
    .clk   (clk),
    .we    (pr_we),
    .waddr (q_addr),
    .wdata ({q_x, q_y}),
    .re    (pr_re),
    .raddr (i[AW-1:0]),
    .rdata (pr_rdata)
  );

  gde_ram #(
    .WIDTH (2*SW),
    .DEPTH (MAX_POINTS-1),
    .AW    (AW)
  ) u_seg_ram (
    .clk   (clk),
    .we    (sg_we),
    .waddr (m),
    .wdata ({lx, ly}),
    .re    (sg_re),
    .raddr (sg_raddr),
    .rdata (sg_rdata)
  );

  // step between neighboring points, snapped to the dominant axis
  assign px  = pr_rdata[2*COORD_BITS-1:COORD_BITS];
  assign py  = pr_rdata[COORD_BITS-1:0];
  assign sdx = $signed({1'b0, px}) - $signed({1'b0, prev_x});
  assign sdy = $signed({1'b0, py}) - $signed({1'b0, prev_y});
  assign adx = sdx[COORD_BITS] ? (COORD_BITS+1)'(-sdx) : (COORD_BITS+1)'(sdx);
  assign ady = sdy[COORD_BITS] ? (COORD_BITS+1)'(-sdy) : (COORD_BITS+1)'(sdy);
  assign stx = (adx > ady) ? SW'(sdx) : '0;
  assign sty = (adx > ady) ? '0 : SW'(sdy);

  assign sx = sg_rdata[2*SW-1:SW];
  assign sy = sg_rdata[SW-1:0];

  assign cx   = (state == S_BPROC) ? stx : sx;
  assign cy   = (state == S_BPROC) ? sty : sy;
  assign jx   = (lx > 0 && cx > 0) || (lx < 0 && cx < 0);
  assign jy   = (ly > 0 && cy > 0) || (ly < 0 && cy < 0);
  assign clen = (cx != 0) ? mag(cx) : mag(cy);
  assign slen = (sx != 0) ? mag(sx) : mag(sy);

  assign rest      = curtot - bestlen;
  assign remove    = ((FW'(rest) << FRAC_BITS) > floor_len);
  assign slot_free = !out_valid || out_ready;
  assign e_last    = (e == n - AW'(1));
  assign pr_we     = (state == S_IDLE) && q_valid && q_ctrl.wr;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    pr_re      = 1'b0;
    sg_re      = 1'b0;
    sg_raddr   = i[AW-1:0];
    feed       = 1'b0;
    sg_we      = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_ctrl.fin) begin
            state_next = S_BRD;
          end
        end
      end
      S_BRD: begin
        if (i == npts) begin
          state_next = S_FLUSH;
        end else begin
          pr_re      = 1'b1;
          state_next = S_BPROC;
        end
      end
      S_BPROC: begin
        feed       = (i != '0);
        state_next = S_BRD;
      end
      S_FLUSH: begin
        sg_we      = !first;
        state_next = building ? S_MUL : S_SRD;
      end
      S_MUL: begin
        state_next = (n == '0) ? S_EMPTY : S_SRD;
      end
      S_SRD: begin
        sg_re      = 1'b1;
        sg_raddr   = j;
        state_next = S_SPROC;
      end
      S_SPROC: begin
        state_next = (j == n - AW'(1)) ? S_DECIDE : S_SRD;
      end
      S_DECIDE: begin
        state_next = remove ? S_RRD : S_ERD;
      end
      S_RRD: begin
        if (i == NW'(n)) begin
          state_next = S_FLUSH;
        end else if (i != NW'(k)) begin
          sg_re      = 1'b1;
          state_next = S_RPROC;
        end
      end
      S_RPROC: begin
        feed       = 1'b1;
        state_next = S_RRD;
      end
      S_ERD: begin
        sg_re      = 1'b1;
        sg_raddr   = e;
        state_next = S_ELD;
      end
      S_ELD: begin
        if (slot_free) begin
          state_next = e_last ? S_IDLE : S_ERD;
        end
      end
      S_EMPTY: begin
        if (slot_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    if (feed && !first && !jx && !jy) begin
      sg_we = 1'b1;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (feed) begin
      if (first) begin
        lx    <= cx;
        ly    <= cy;
        first <= 1'b0;
      end else if (jx || jy) begin
        if (jx) begin
          lx <= lx + cx;
        end
        if (jy) begin
          ly <= ly + cy;
        end
      end else begin
        m  <= m + AW'(1);
        lx <= cx;
        ly <= cy;
      end
    end
    unique case (state)
      S_IDLE: begin
        if (q_valid && q_ctrl.fin) begin
          npts     <= q_npts;
          i        <= '0;
          m        <= '0;
          first    <= 1'b1;
          tot      <= '0;
          building <= 1'b1;
        end
      end
      S_BPROC: begin
        prev_x <= px;
        prev_y <= py;
        i      <= i + NW'(1);
        if (i != '0) begin
          tot <= tot + clen;
        end
      end
      S_FLUSH: begin
        n         <= first ? m : m + AW'(1);
        j         <= '0;
        up_cnt    <= '0;
        down_cnt  <= '0;
        left_cnt  <= '0;
        right_cnt <= '0;
      end
      S_MUL: begin
        floor_len <= FW'(tot) * FW'(min_match);
        curtot    <= tot;
      end
      S_SPROC: begin
        if (j == '0 || slen < bestlen) begin
          bestlen <= slen;
          k       <= j;
        end
        if (sx == 0) begin
          if (!sy[SW-1]) begin
            up_cnt <= up_cnt + AW'(1);
          end else begin
            down_cnt <= down_cnt + AW'(1);
          end
        end else if (sy == 0) begin
          if (!sx[SW-1]) begin
            left_cnt <= left_cnt + AW'(1);
          end else begin
            right_cnt <= right_cnt + AW'(1);
          end
        end
        j <= j + AW'(1);
      end
      S_DECIDE: begin
        e <= '0;
        if (remove) begin
          curtot   <= rest;
          i        <= '0;
          m        <= '0;
          first    <= 1'b1;
          building <= 1'b0;
        end
      end
      S_RRD: begin
        if (i != NW'(n) && i == NW'(k)) begin
          i <= i + NW'(1);
        end
      end
      S_RPROC: begin
        i <= i + NW'(1);
      end
      S_ELD: begin
        if (slot_free) begin
          e <= e + AW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_ELD || state == S_EMPTY) && slot_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_ELD && slot_free) begin
      seg_dx        <= OUT_BITS'(sx);
      seg_dy        <= OUT_BITS'(sy);
      segment_valid <= 1'b1;
      up_count      <= CNT_BITS'(up_cnt);
      down_count    <= CNT_BITS'(down_cnt);
      left_count    <= CNT_BITS'(left_cnt);
      right_count   <= CNT_BITS'(right_cnt);
      last_segment  <= e_last;
    end else if (state == S_EMPTY && slot_free) begin
      seg_dx        <= '0;
      seg_dy        <= '0;
      segment_valid <= 1'b0;
      up_count      <= '0;
      down_count    <= '0;
      left_count    <= '0;
      right_count   <= '0;
      last_segment  <= 1'b1;
    end
  end

  `GDE_ASSERT_NXT(a_last_returns_idle, state == S_ELD && slot_free && e_last,
                  state == S_IDLE && out_valid)
  `GDE_ASSERT_IMP(a_stroke_one_axis, state == S_ELD && slot_free, (sx == 0) != (sy == 0))
  `GDE_ASSERT_IMP(a_shortest_within_total, state == S_DECIDE, bestlen <= curtot)
  `GDE_ASSERT_IMP(a_scan_in_range, state == S_SPROC, j < n)

endmodule
`default_nettype wire

// ===== src/gesture_direction_extractor.sv =====
// top level of the gesture direction extractor
`timescale 1ns / 1ps
`default_nettype none
// Collects pointer samples of one gesture (start, move, end requests on the input
// channel) and on end reduces the path to axis-aligned strokes, which leave on the
// output channel one per result, each carrying the up/down/left/right counts of the
// whole gesture, last_segment high on the final one; an end that yields no stroke
// gives a single result with segment_valid low. The front accepts one request per
// cycle while the queue has room and hands store and end requests to the back
// through a two-entry queue, so a burst of pointer samples streams in at one per
// cycle while the back is idle. The end request is handled by the back alone: it
// builds and merges strokes from the stored points, then in each removal round
// scans for the shortest stroke and rebuilds the list without it, then emits the
// strokes one by one; each memory is read through its single read port. No clearing
// pass is needed after reset. The user must write min_match through
// cfg_we/cfg_wdata only while the block is idle, which the block does not enforce.
module gesture_direction_extractor #(
  parameter int MAX_POINTS = gde_pkg::MAX_POINTS_DEF,
  parameter int COORD_BITS = gde_pkg::COORD_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [gde_pkg::MATCH_BITS-1:0]    cfg_wdata,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [1:0]                        command,
  input  wire logic [COORD_BITS-1:0]             pos_x,
  input  wire logic [COORD_BITS-1:0]             pos_y,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic signed [gde_pkg::OUT_BITS-1:0]    seg_dx,
  output logic signed [gde_pkg::OUT_BITS-1:0]    seg_dy,
  output logic                                   segment_valid,
  output logic [gde_pkg::CNT_BITS-1:0]           up_count,
  output logic [gde_pkg::CNT_BITS-1:0]           down_count,
  output logic [gde_pkg::CNT_BITS-1:0]           left_count,
  output logic [gde_pkg::CNT_BITS-1:0]           right_count,
  output logic                                   last_segment
);
  import gde_pkg::*;

  // point index, point count and stroke width (wide enough for a whole-path sum)
  localparam int AW = $clog2(MAX_POINTS);
  localparam int NW = $clog2(MAX_POINTS + 1);
  localparam int SW = COORD_BITS + AW + 1;
  localparam int CW = $bits(op_ctrl_t);
  localparam int QW = CW + AW + 2*COORD_BITS + NW;

  logic [MATCH_BITS-1:0] min_match;

  // front side of the queue
  logic                  f_push;
  op_ctrl_t              f_ctrl;
  logic [AW-1:0]         f_addr;
  logic [COORD_BITS-1:0] f_x;
  logic [COORD_BITS-1:0] f_y;
  logic [NW-1:0]         f_npts;
  logic                  q_ready;

  // back side of the queue
  logic                  q_valid;
  logic                  q_pop;
  logic [QW-1:0]         q_dout;
  op_ctrl_t              b_ctrl;
  logic [AW-1:0]         b_addr;
  logic [COORD_BITS-1:0] b_x;
  logic [COORD_BITS-1:0] b_y;
  logic [NW-1:0]         b_npts;

  // match threshold register, no read-back
  always_ff @(posedge clk) begin
    if (rst) begin
      min_match <= MATCH_RESET;
    end else if (cfg_we) begin
      min_match <= cfg_wdata;
    end
  end

  gde_front #(
    .MAX_POINTS (MAX_POINTS),
    .COORD_BITS (COORD_BITS),
    .AW         (AW),
    .NW         (NW)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .command  (command),
    .pos_x    (pos_x),
    .pos_y    (pos_y),
    .q_ready  (q_ready),
    .q_push   (f_push),
    .q_ctrl   (f_ctrl),
    .q_addr   (f_addr),
    .q_x      (f_x),
    .q_y      (f_y),
    .q_npts   (f_npts)
  );

  gde_fifo #(
    .W (QW)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (f_push),
    .din   ({f_ctrl, f_addr, f_x, f_y, f_npts}),
    .ready (q_ready),
    .valid (q_valid),
    .pop   (q_pop),
    .dout  (q_dout)
  );

  assign {b_ctrl, b_addr, b_x, b_y, b_npts} = q_dout;

  gde_back #(
    .MAX_POINTS (MAX_POINTS),
    .COORD_BITS (COORD_BITS),
    .AW         (AW),
    .NW         (NW),
    .SW         (SW)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .min_match     (min_match),
    .q_valid       (q_valid),
    .q_pop         (q_pop),
    .q_ctrl        (b_ctrl),
    .q_addr        (b_addr),
    .q_x           (b_x),
    .q_y           (b_y),
    .q_npts        (b_npts),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .seg_dx        (seg_dx),
    .seg_dy        (seg_dy),
    .segment_valid (segment_valid),
    .up_count      (up_count),
    .down_count    (down_count),
    .left_count    (left_count),
    .right_count   (right_count),
    .last_segment  (last_segment)
  );

endmodule
`default_nettype wire

// ===== sim/testbench.sv =====
// self-checking testbench for the gesture direction extractor
`timescale 1ns / 1ps
`default_nettype none
module testbench;
  import gde_pkg::*;

  // stroke record as emitted by the block
  typedef struct {
    logic signed [OUT_BITS-1:0] dx;
    logic signed [OUT_BITS-1:0] dy;
    logic                       seg_ok;
    logic [CNT_BITS-1:0]        n_up;
    logic [CNT_BITS-1:0]        n_down;
    logic [CNT_BITS-1:0]        n_left;
    logic [CNT_BITS-1:0]        n_right;
    logic                       last;
  } stroke_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [MATCH_BITS-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] command = CMD_NONE;
  logic [11:0] pos_x = '0;
  logic [11:0] pos_y = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [OUT_BITS-1:0] seg_dx, seg_dy;
  logic segment_valid, last_segment;
  logic [CNT_BITS-1:0] up_count, down_count, left_count, right_count;

  gesture_direction_extractor dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .command(command),
    .pos_x(pos_x), .pos_y(pos_y), .out_valid(out_valid), .out_ready(out_ready),
    .seg_dx(seg_dx), .seg_dy(seg_dy), .segment_valid(segment_valid),
    .up_count(up_count), .down_count(down_count), .left_count(left_count),
    .right_count(right_count), .last_segment(last_segment)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor state
  int unsigned match_frac = MATCH_RESET;
  int px[64];
  int py[64];
  int npts = 0;
  bit drawing = 0;
  longint sx[64];
  longint sy[64];

  stroke_t stroke_q[$];
  int errors = 0;
  bit calm = 0;      // no idling on either side

  function automatic longint mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint stroke_len(int k);
    return sx[k] != 0 ? mag(sx[k]) : mag(sy[k]);
  endfunction

  function automatic longint path_len(int n);
    longint s = 0;
    for (int i = 0; i < n; i++) s += stroke_len(i);
    return s;
  endfunction

  // join neighbors of the same sign
  function automatic int join_runs(int n);
    int m = 0;
    longint lx = 0, ly = 0, cx, cy;
    bit joined;
    for (int i = 0; i < n; i++) begin
      if (i == 0) begin
        lx = sx[0];
        ly = sy[0];
      end else begin
        joined = 0;
        cx = sx[i];
        cy = sy[i];
        if ((lx > 0 && cx > 0) || (lx < 0 && cx < 0)) begin
          lx += cx;
          joined = 1;
        end
        if ((ly > 0 && cy > 0) || (ly < 0 && cy < 0)) begin
          ly += cy;
          joined = 1;
        end
        if (!joined) begin
          sx[m] = lx;
          sy[m] = ly;
          m++;
          lx = cx;
          ly = cy;
        end
      end
    end
    if (lx != 0 || ly != 0) begin
      sx[m] = lx;
      sy[m] = ly;
      m++;
    end
    return m;
  endfunction

  function automatic void keep_pt(int x, int y);
    if (npts < 64) begin
      px[npts] = x;
      py[npts] = y;
      npts++;
    end
  endfunction

  // reduce the stored path to strokes and queue the expected results
  function automatic void close_gesture();
    int n = 0, k;
    longint dx, dy, floor_len, rest, best, sq;
    int cu = 0, cd = 0, cl = 0, cr = 0;
    stroke_t r;
    for (int i = 1; i < npts; i++) begin
      dx = px[i] - px[i-1];
      dy = py[i] - py[i-1];
      if (dy > 0) begin
        if (dx > dy || -dx > dy) dy = 0; else dx = 0;
      end else begin
        if (dx > -dy || -dx > -dy) dy = 0; else dx = 0;
      end
      sx[n] = dx;
      sy[n] = dy;
      n++;
    end
    n = join_runs(n);
    floor_len = path_len(n) * match_frac;
    while (n > 0) begin
      k = 0;
      best = 0;
      for (int i = 0; i < n; i++) begin
        sq = sx[i] * sx[i] + sy[i] * sy[i];
        if (i == 0 || sq < best) begin
          best = sq;
          k = i;
        end
      end
      rest = path_len(n) - stroke_len(k);
      if (!(rest * 256 > floor_len)) break;
      for (int i = k; i + 1 < n; i++) begin
        sx[i] = sx[i+1];
        sy[i] = sy[i+1];
      end
      n = join_runs(n - 1);
    end
    for (int i = 0; i < n; i++) begin
      if (sx[i] == 0 && sy[i] >= 0) cu++;
      else if (sx[i] == 0) cd++;
      else if (sy[i] == 0 && sx[i] >= 0) cl++;
      else if (sy[i] == 0) cr++;
    end
    if (n == 0) begin
      r = '{0, 0, 0, 0, 0, 0, 0, 1};
      stroke_q = {stroke_q, r};
    end
    for (int i = 0; i < n; i++) begin
      r.dx = sx[i][OUT_BITS-1:0];
      r.dy = sy[i][OUT_BITS-1:0];
      r.seg_ok = 1;
      r.n_up = cu[CNT_BITS-1:0];
      r.n_down = cd[CNT_BITS-1:0];
      r.n_left = cl[CNT_BITS-1:0];
      r.n_right = cr[CNT_BITS-1:0];
      r.last = (i == n - 1);
      stroke_q = {stroke_q, r};
    end
  endfunction

  function automatic void predict(cmd_t c, int x, int y);
    int dx, dy;
    if (c == CMD_START) begin
      npts = 0;
      drawing = 1;
      keep_pt(x, y);
      return;
    end
    if (c == CMD_NONE || !drawing || npts == 0) return;
    dx = x - px[npts-1];
    dy = y - py[npts-1];
    if (c == CMD_MOVE) begin
      if (dx * dx + dy * dy >= 5) keep_pt(x, y);
      return;
    end
    if (dx != 0 || dy != 0) keep_pt(x, y);
    close_gesture();
    npts = 0;
    drawing = 0;
  endfunction

  // send one request, idling at random beforehand
  task automatic send_req(cmd_t c, int x, int y);
    while (!calm && $urandom_range(99) < 29) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    command <= c;
    pos_x <= x[11:0];
    pos_y <= y[11:0];
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict(c, x, y);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (stroke_q.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic set_match(int v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v[MATCH_BITS-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    match_frac = v;
  endtask

  // receiver: random stall, check each accepted result
  always @(posedge clk) begin
    stroke_t e;
    if (!rst && out_valid && out_ready) begin
      if (stroke_q.size() == 0) begin
        $error("unexpected result dx=%0d dy=%0d", seg_dx, seg_dy);
        errors++;
      end else begin
        e = stroke_q.pop_front();
        if (seg_dx !== e.dx) begin
          $error("seg_dx expected %0d got %0d", e.dx, seg_dx); errors++;
        end
        if (seg_dy !== e.dy) begin
          $error("seg_dy expected %0d got %0d", e.dy, seg_dy); errors++;
        end
        if (segment_valid !== e.seg_ok) begin
          $error("segment_valid expected %0d got %0d", e.seg_ok, segment_valid);
          errors++;
        end
        if (up_count !== e.n_up) begin
          $error("up_count expected %0d got %0d", e.n_up, up_count); errors++;
        end
        if (down_count !== e.n_down) begin
          $error("down_count expected %0d got %0d", e.n_down, down_count); errors++;
        end
        if (left_count !== e.n_left) begin
          $error("left_count expected %0d got %0d", e.n_left, left_count); errors++;
        end
        if (right_count !== e.n_right) begin
          $error("right_count expected %0d got %0d", e.n_right, right_count);
          errors++;
        end
        if (last_segment !== e.last) begin
          $error("last_segment expected %0d got %0d", e.last, last_segment);
          errors++;
        end
      end
    end
    out_ready <= calm || ($urandom_range(99) >= 29);
  end

  // directed: extremes, ignored commands, empty gesture, overflow of store
  task automatic test_directed();
    send_req(CMD_MOVE, 10, 10);          // move before start
    send_req(CMD_END, 10, 10);           // end before start
    send_req(CMD_START, 0, 0);
    send_req(CMD_END, 0, 0);             // empty gesture
    send_req(CMD_START, 0, 0);
    send_req(CMD_MOVE, 1, 1);            // too close
    send_req(CMD_NONE, 4095, 4095);      // ignored
    send_req(CMD_MOVE, 4095, 0);
    send_req(CMD_MOVE, 4095, 4095);
    send_req(CMD_MOVE, 0, 4095);
    send_req(CMD_END, 0, 0);
    send_req(CMD_START, 2048, 2048);
    send_req(CMD_MOVE, 2100, 2100);      // diagonal tie
    send_req(CMD_END, 2000, 2150);
    // more points than the store holds
    send_req(CMD_START, 100, 100);
    for (int i = 1; i <= 70; i++)
      send_req(CMD_MOVE, 100 + 10 * i, (i % 2) ? 100 : 140);
    send_req(CMD_END, 100, 100);
  endtask

  task automatic one_gesture(int npt);
    int x = $urandom_range(4095), y = $urandom_range(4095);
    send_req(CMD_START, x, y);
    for (int i = 0; i < npt; i++) begin
      if ($urandom_range(9) == 0) begin
        send_req(cmd_t'($urandom_range(3)), $urandom_range(4095), $urandom_range(4095));
      end else begin
        x = x + $urandom_range(80) - 40;
        y = y + $urandom_range(80) - 40;
        x = x < 0 ? 0 : (x > 4095 ? 4095 : x);
        y = y < 0 ? 0 : (y > 4095 ? 4095 : y);
        send_req(CMD_MOVE, x, y);
      end
    end
    send_req(CMD_END, x, y);
  endtask

  task automatic test_random(int items);
    int done = 0, n;
    while (done < items) begin
      n = $urandom_range(8, 1);
      one_gesture(n);
      done += n + 2;
    end
  endtask

  task automatic test_match_sweep();
    set_match(0);
    test_random(8);
    set_match(256);
    test_random(8);
    set_match($urandom_range(255, 1));
    calm = 1;
    test_random(8);
    calm = 0;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random(10);
    test_match_sweep();
    drain();
    if (errors == 0 && stroke_q.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  initial begin
    #20ms;
    $display("TEST FAILED");
    $finish;
  end
endmodule
`default_nettype wire
